// ----- rtl/lsm_pkg.sv -----
// Package with the shared types, codes and constants of the link supervisor.
package lsm_pkg;

    localparam int TICK_COUNT_WIDTH = 32;
    localparam int TIMEOUT_WIDTH    = 16;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int MODE_WIDTH       = 3;

    typedef enum logic [1:0] {
        LINK_NOT_CONNECTED = 2'd0,
        LINK_IDLE          = 2'd1,
        LINK_ACCEPTING     = 2'd2,
        LINK_IN_CONTROL    = 2'd3
    } t_link_status;

    typedef enum logic [1:0] {
        CTRL_NOT_RUNNING = 2'd0,
        CTRL_DRIVE       = 2'd1,
        CTRL_PARK        = 2'd2,
        CTRL_UNDEFINED   = 2'd3
    } t_ctrl_status;

    typedef enum logic [1:0] {
        CERR_NONE        = 2'd0,
        CERR_PARKED      = 2'd1,
        CERR_NOT_RUNNING = 2'd2
    } t_ctrl_error;

    typedef enum logic [1:0] {
        LERR_NONE          = 2'd0,
        LERR_NOT_CONNECTED = 2'd1,
        LERR_NO_DATA       = 2'd2
    } t_link_error;

    typedef enum logic [1:0] {
        REG_REQUIRE_CTRL = 2'd0,
        REG_CTRL_TIMEOUT = 2'd1,
        REG_LINK_TIMEOUT = 2'd2
    } t_reg_index;

    typedef enum logic [4:0] {
        MODE_STANDBY  = 5'b00001,
        MODE_LISTEN   = 5'b00010,
        MODE_COMMAND  = 5'b00100,
        MODE_CTRL_ERR = 5'b01000,
        MODE_LINK_ERR = 5'b10000
    } t_mode;

    localparam logic [MODE_WIDTH-1:0] CODE_STANDBY  = 3'd0;
    localparam logic [MODE_WIDTH-1:0] CODE_LISTEN   = 3'd1;
    localparam logic [MODE_WIDTH-1:0] CODE_COMMAND  = 3'd2;
    localparam logic [MODE_WIDTH-1:0] CODE_CTRL_ERR = 3'd3;
    localparam logic [MODE_WIDTH-1:0] CODE_LINK_ERR = 3'd4;

    typedef struct packed {
        t_mode       mode;
        t_ctrl_error cerr;
        t_link_error lerr;
    } t_state;

    typedef struct packed {
        logic require_ctrl;
        logic ctrl_timed_out;
        logic link_timed_out;
    } t_flags;

    function automatic logic [MODE_WIDTH-1:0] mode_code(input t_mode m);
        logic [MODE_WIDTH-1:0] c;
        case (m)
            MODE_STANDBY:  c = CODE_STANDBY;
            MODE_LISTEN:   c = CODE_LISTEN;
            MODE_COMMAND:  c = CODE_COMMAND;
            MODE_CTRL_ERR: c = CODE_CTRL_ERR;
            MODE_LINK_ERR: c = CODE_LINK_ERR;
            default:       c = CODE_STANDBY;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/lsm_in_if.sv -----
// Interface of the tick input channel.
interface lsm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] link_status;
    logic [1:0] controller_status;
    logic       data_present;

    modport source (output valid, output link_status, output controller_status,
                    output data_present, input ready);
    modport sink (input valid, input link_status, input controller_status,
                  input data_present, output ready);
endinterface

// ----- rtl/lsm_out_if.sv -----
// Interface of the result output channel.
interface lsm_out_if;
    logic                            valid;
    logic                            ready;
    logic [lsm_pkg::MODE_WIDTH-1:0]  mode_now;
    logic                            mode_changed;
    logic [1:0]                      controller_error;
    logic [1:0]                      link_error;

    modport source (output valid, output mode_now, output mode_changed,
                    output controller_error, output link_error, input ready);
    modport sink (input valid, input mode_now, input mode_changed,
                  input controller_error, input link_error, output ready);
endinterface

// ----- rtl/lsm_cfg_if.sv -----
// Interface of the configuration write channel.
interface lsm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lsm_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [lsm_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/lsm_next.sv -----
// Next-state logic of the supervisor mode machine for one tick.
module lsm_next (
    input  lsm_pkg::t_state       i_cur,
    input  lsm_pkg::t_flags       i_flags,
    input  lsm_pkg::t_link_status i_link,
    input  lsm_pkg::t_ctrl_status i_ctrl,
    input  logic                  i_data,
    output lsm_pkg::t_state       o_next
);

    logic check_errors;
    logic ctrl_parked;
    logic ctrl_dead;
    logic link_dead;
    logic no_data;

    always_comb begin
        ctrl_parked = (i_ctrl == lsm_pkg::CTRL_PARK);
        ctrl_dead   = i_flags.require_ctrl && (i_ctrl == lsm_pkg::CTRL_NOT_RUNNING)
                      && ((i_cur.mode == lsm_pkg::MODE_COMMAND) || i_flags.ctrl_timed_out);
        link_dead   = (i_link == lsm_pkg::LINK_NOT_CONNECTED)
                      && ((i_cur.mode != lsm_pkg::MODE_STANDBY) || i_flags.link_timed_out);
        no_data     = !i_data && (i_cur.mode != lsm_pkg::MODE_STANDBY);
    end

    always_comb begin
        o_next       = i_cur;
        check_errors = 1'b0;
        case (i_cur.mode)
            lsm_pkg::MODE_STANDBY: begin
                if (i_data) begin
                    o_next.mode = lsm_pkg::MODE_LISTEN;
                end else begin
                    check_errors = 1'b1;
                end
            end
            lsm_pkg::MODE_LISTEN: begin
                if ((i_link == lsm_pkg::LINK_ACCEPTING) &&
                    ((i_ctrl == lsm_pkg::CTRL_DRIVE) || !i_flags.require_ctrl)) begin
                    o_next.mode = lsm_pkg::MODE_COMMAND;
                end else begin
                    check_errors = 1'b1;
                end
            end
            lsm_pkg::MODE_COMMAND: begin
                if ((i_link == lsm_pkg::LINK_IDLE) || (i_link == lsm_pkg::LINK_IN_CONTROL)) begin
                    o_next.mode = lsm_pkg::MODE_LISTEN;
                end else begin
                    check_errors = 1'b1;
                end
            end
            lsm_pkg::MODE_CTRL_ERR: begin
                if (i_ctrl == lsm_pkg::CTRL_DRIVE) begin
                    o_next.cerr = lsm_pkg::CERR_NONE;
                    o_next.mode = lsm_pkg::MODE_STANDBY;
                end
            end
            lsm_pkg::MODE_LINK_ERR: begin
                if (((i_cur.lerr == lsm_pkg::LERR_NOT_CONNECTED) &&
                     (i_link != lsm_pkg::LINK_NOT_CONNECTED)) ||
                    ((i_cur.lerr == lsm_pkg::LERR_NO_DATA) && i_data)) begin
                    o_next.lerr = lsm_pkg::LERR_NONE;
                    o_next.mode = lsm_pkg::MODE_STANDBY;
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase

        if (check_errors) begin
            if (ctrl_parked) begin
                o_next.cerr = lsm_pkg::CERR_PARKED;
                o_next.mode = lsm_pkg::MODE_CTRL_ERR;
            end else if (ctrl_dead) begin
                o_next.cerr = lsm_pkg::CERR_NOT_RUNNING;
                o_next.mode = lsm_pkg::MODE_CTRL_ERR;
            end else if (link_dead) begin
                o_next.lerr = lsm_pkg::LERR_NOT_CONNECTED;
                o_next.mode = lsm_pkg::MODE_LINK_ERR;
            end else if (no_data) begin
                o_next.lerr = lsm_pkg::LERR_NO_DATA;
                o_next.mode = lsm_pkg::MODE_LINK_ERR;
            end
        end
    end

endmodule

// ----- rtl/link_supervisor_mode_fsm.sv -----
// Top level of the link supervisor: mode machine, tick counter and result register.
//
// Channel   Direction  Word
// i_in      sink       link_status, controller_status, data_present (one tick)
// o_out     source     mode_now, mode_changed, controller_error, link_error
// i_cfg     sink       index, data (register write; unknown indexes are dropped)
//
// Every tick word is evaluated in the cycle it is accepted; its result sits in the
// output register from the next cycle on. One word per cycle is accepted while i_in.ready is high.
// i_in.ready is low only while a result waits and o_out.ready is low.
// Reset clears the mode, both error codes and the tick counter, and loads the register defaults.
// i_cfg.ready is always high.
module link_supervisor_mode_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lsm_in_if.sink           i_in,
    lsm_out_if.source        o_out,
    lsm_cfg_if.sink          i_cfg
);

    logic                                   r_require_ctrl;
    logic [lsm_pkg::TIMEOUT_WIDTH-1:0]      r_ctrl_timeout;
    logic [lsm_pkg::TIMEOUT_WIDTH-1:0]      r_link_timeout;
    lsm_pkg::t_state                        r_state;
    lsm_pkg::t_state                        n_state;
    logic [lsm_pkg::TICK_COUNT_WIDTH-1:0]   r_ticks;
    logic [lsm_pkg::TICK_COUNT_WIDTH-1:0]   n_ticks;
    lsm_pkg::t_flags                        flags;
    logic                                   in_accept;
    logic                                   r_out_valid;
    logic [lsm_pkg::MODE_WIDTH-1:0]         r_out_mode;
    logic                                   r_out_changed;
    logic [1:0]                             r_out_cerr;
    logic [1:0]                             r_out_lerr;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    always_comb begin
        flags.require_ctrl   = r_require_ctrl;
        flags.ctrl_timed_out = r_ticks >
            {{(lsm_pkg::TICK_COUNT_WIDTH - lsm_pkg::TIMEOUT_WIDTH){1'b0}}, r_ctrl_timeout};
        flags.link_timed_out = r_ticks >
            {{(lsm_pkg::TICK_COUNT_WIDTH - lsm_pkg::TIMEOUT_WIDTH){1'b0}}, r_link_timeout};
        n_ticks = (r_ticks == {lsm_pkg::TICK_COUNT_WIDTH{1'b1}}) ? r_ticks
                : r_ticks + {{(lsm_pkg::TICK_COUNT_WIDTH - 1){1'b0}}, 1'b1};
    end

    lsm_next u_next (
        .i_cur   (r_state),
        .i_flags (flags),
        .i_link  (lsm_pkg::t_link_status'(i_in.link_status)),
        .i_ctrl  (lsm_pkg::t_ctrl_status'(i_in.controller_status)),
        .i_data  (i_in.data_present),
        .o_next  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_ctrl <= 1'b1;
            r_ctrl_timeout <= lsm_pkg::TIMEOUT_WIDTH'(10);
            r_link_timeout <= lsm_pkg::TIMEOUT_WIDTH'(10);
        end else if (i_cfg.valid) begin
            case (lsm_pkg::t_reg_index'(i_cfg.index))
                lsm_pkg::REG_REQUIRE_CTRL: r_require_ctrl <= i_cfg.data[0];
                lsm_pkg::REG_CTRL_TIMEOUT: r_ctrl_timeout <= i_cfg.data;
                lsm_pkg::REG_LINK_TIMEOUT: r_link_timeout <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode <= lsm_pkg::MODE_STANDBY;
            r_state.cerr <= lsm_pkg::CERR_NONE;
            r_state.lerr <= lsm_pkg::LERR_NONE;
            r_ticks      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
                r_ticks <= n_ticks;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_mode    <= lsm_pkg::mode_code(n_state.mode);
            r_out_changed <= (n_state.mode != r_state.mode);
            r_out_cerr    <= n_state.cerr;
            r_out_lerr    <= n_state.lerr;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.mode_now         = r_out_mode;
    assign o_out.mode_changed     = r_out_changed;
    assign o_out.controller_error = r_out_cerr;
    assign o_out.link_error       = r_out_lerr;

    a_ctrl_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == lsm_pkg::MODE_CTRL_ERR) |-> (r_state.cerr != lsm_pkg::CERR_NONE))
        else $error("Controller error mode is held without an error code.");

    a_link_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == lsm_pkg::MODE_LINK_ERR) |-> (r_state.lerr != lsm_pkg::LERR_NONE))
        else $error("Link error mode is held without an error code.");

    a_ticks_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_ticks >= $past(r_ticks)))
        else $error("The tick counter went backward without a reset.");

    a_state_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_state) && $stable(r_ticks))
        else $error("The mode state moved without an accepted tick word.");

endmodule
